/* hdl/pvcs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pvcs_pkg;

    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int DIV_BITS   = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_BITS);

    localparam logic [CFG_W-1:0] RST_TOGGLE_INTERVAL = 16'd500;
    localparam logic [CFG_W-1:0] RST_BALANCE_DELAY   = 16'd10;
    localparam logic [CFG_W-1:0] RST_BALANCE_WINDOW  = 16'd5000;
    localparam logic [CFG_W-1:0] RST_BALANCE_ALT     = 16'd500;

    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_DELAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_WINDOW  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BALANCE_ALT     = 2'd3;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;
    localparam logic [1:0] KIND_ESTOP = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
    } t_in_beat;

    typedef struct packed {
        logic pump_on;
        logic valve_a_open;
        logic valve_b_open;
        logic is_running;
        logic is_balancing;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

/* hdl/pvcs_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module pvcs_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [pvcs_pkg::DIV_BITS-1:0]     i_dividend,
    input  wire logic [pvcs_pkg::DIV_BITS-1:0]     i_divisor,
    output logic                                   o_done,
    output logic                                   o_q_lsb
);

    logic                               r_busy;
    logic                               n_busy;
    logic [pvcs_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [pvcs_pkg::DIV_CNT_W-1:0]     n_cnt;
    logic [pvcs_pkg::DIV_BITS-1:0]      r_dvd;
    logic [pvcs_pkg::DIV_BITS-1:0]      n_dvd;
    logic [pvcs_pkg::DIV_BITS-1:0]      r_rem;
    logic [pvcs_pkg::DIV_BITS-1:0]      n_rem;
    logic [pvcs_pkg::DIV_BITS-1:0]      r_dsr;
    logic [pvcs_pkg::DIV_BITS-1:0]      n_dsr;
    logic [pvcs_pkg::DIV_BITS:0]        w_shift;
    logic [pvcs_pkg::DIV_BITS:0]        w_diff;
    logic                               w_ge;

    always_comb begin
        w_shift = {r_rem, r_dvd[pvcs_pkg::DIV_BITS-1]};
        w_diff  = w_shift - {1'b0, r_dsr};
        w_ge    = (w_shift >= {1'b0, r_dsr});
        o_done  = r_busy && (r_cnt == '0);
        o_q_lsb = w_ge;

        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = pvcs_pkg::DIV_CNT_W'(pvcs_pkg::DIV_BITS - 1);
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_dvd = {r_dvd[pvcs_pkg::DIV_BITS-2:0], 1'b0};
            n_rem = w_ge ? w_diff[pvcs_pkg::DIV_BITS-1:0] : w_shift[pvcs_pkg::DIV_BITS-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

endmodule

`default_nettype wire

/* hdl/pump_valve_cycle_sequencer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// An input beat is captured in ST_IDLE and processed in ST_EXEC; a tick inside
// the balancing window then passes through ST_DIV, where the 16-step serial divider sets the alternation slot.
// ST_DONE loads the output register. No new beat is accepted until ST_DONE has loaded
// the output register, which waits while the output register holds a beat for a stalled receiver.
// Reset (synchronous, active low): all flags and reference times clear, registers
// return to their default values, output beat dropped.

module pump_valve_cycle_sequencer_top #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire pvcs_pkg::t_in_beat                    i_in_data,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output pvcs_pkg::t_out_beat                        o_out_data,
    input  wire logic                                  i_cfg_we,
    input  wire logic [pvcs_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [pvcs_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int EW = (TIME_BITS > pvcs_pkg::CFG_W + 1) ? TIME_BITS : pvcs_pkg::CFG_W + 1;

    pvcs_pkg::t_state               r_state;
    pvcs_pkg::t_state               n_state;

    logic [pvcs_pkg::CFG_W-1:0]     r_toggle_int;
    logic [pvcs_pkg::CFG_W-1:0]     r_bal_delay;
    logic [pvcs_pkg::CFG_W-1:0]     r_bal_window;
    logic [pvcs_pkg::CFG_W-1:0]     r_bal_alt;

    logic                           r_running;
    logic                           n_running;
    logic                           r_balancing;
    logic                           n_balancing;
    logic                           r_paired;
    logic                           n_paired;
    logic                           r_bva;
    logic                           n_bva;
    logic                           r_selb;
    logic                           n_selb;
    logic [TIME_BITS-1:0]           r_cyc_ref;
    logic [TIME_BITS-1:0]           n_cyc_ref;
    logic [TIME_BITS-1:0]           r_bal_ref;
    logic [TIME_BITS-1:0]           n_bal_ref;

    logic [1:0]                     r_kind;
    logic [TIME_BITS-1:0]           r_now;
    logic                           r_out_valid;
    logic                           n_out_valid;
    pvcs_pkg::t_out_beat            r_out_data;
    pvcs_pkg::t_out_beat            n_out_data;

    logic [63:0]                    w_now64;
    logic [TIME_BITS-1:0]           w_cyc_delta;
    logic [TIME_BITS-1:0]           w_bal_ref_eff;
    logic [TIME_BITS-1:0]           w_elapsed;
    logic [EW-1:0]                  w_elapsed_x;
    logic [EW-1:0]                  w_win_end;
    logic                           w_active;
    logic                           w_ended;
    logic [pvcs_pkg::CFG_W-1:0]     w_offset;
    logic [pvcs_pkg::CFG_W-1:0]     w_period;
    logic                           w_div_start;
    logic                           w_div_done;
    logic                           w_div_q;
    logic                           w_in_acc;
    logic                           w_va;
    logic                           w_vb;

    assign w_now64  = {32'd0, i_in_data.now_ms};
    assign w_in_acc = i_in_valid && o_in_ready;

    always_comb begin
        w_cyc_delta   = r_now - r_cyc_ref;
        w_bal_ref_eff = (r_bal_ref == '0) ? r_now : r_bal_ref;
        w_elapsed     = r_now - w_bal_ref_eff;
        w_elapsed_x   = EW'(w_elapsed);
        w_win_end     = EW'(r_bal_delay) + EW'(r_bal_window);
        w_active      = (w_elapsed_x >= EW'(r_bal_delay)) && (w_elapsed_x < w_win_end);
        w_ended       = (w_elapsed_x >= w_win_end);
        w_offset      = w_elapsed[pvcs_pkg::CFG_W-1:0] - r_bal_delay;
        w_period      = (r_bal_alt == '0) ? pvcs_pkg::CFG_W'(1) : r_bal_alt;
    end

    pvcs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_offset),
        .i_divisor  (w_period),
        .o_done     (w_div_done),
        .o_q_lsb    (w_div_q)
    );

    always_comb begin
        n_state     = r_state;
        n_running   = r_running;
        n_balancing = r_balancing;
        n_paired    = r_paired;
        n_bva       = r_bva;
        n_selb      = r_selb;
        n_cyc_ref   = r_cyc_ref;
        n_bal_ref   = r_bal_ref;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_div_start = 1'b0;
        o_in_ready  = 1'b0;
        w_va        = r_running && r_paired;
        w_vb        = r_running && r_paired;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            pvcs_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (w_in_acc) begin
                    n_state = pvcs_pkg::ST_EXEC;
                end
            end
            pvcs_pkg::ST_EXEC: begin
                n_state = pvcs_pkg::ST_DONE;
                case (r_kind)
                    pvcs_pkg::KIND_TICK: begin
                        if (r_running) begin
                            if (r_cyc_ref == '0) begin
                                n_cyc_ref = r_now;
                            end else if (EW'(w_cyc_delta) >= EW'(r_toggle_int)) begin
                                n_paired  = !r_paired;
                                n_cyc_ref = r_now;
                            end
                        end
                        if (r_balancing) begin
                            n_bal_ref = w_bal_ref_eff;
                            n_bva     = w_active;
                            if (w_active) begin
                                w_div_start = 1'b1;
                                n_state     = pvcs_pkg::ST_DIV;
                            end
                            if (w_ended) begin
                                n_balancing = 1'b0;
                                n_bva       = 1'b0;
                                n_selb      = 1'b0;
                            end
                        end
                    end
                    pvcs_pkg::KIND_START: begin
                        n_running   = 1'b1;
                        n_balancing = 1'b0;
                        n_paired    = 1'b1;
                        n_bva       = 1'b0;
                        n_selb      = 1'b0;
                        n_cyc_ref   = '0;
                    end
                    pvcs_pkg::KIND_STOP: begin
                        if (r_running) begin
                            n_running   = 1'b0;
                            n_balancing = 1'b1;
                            n_paired    = 1'b0;
                            n_bva       = 1'b0;
                            n_selb      = 1'b0;
                            n_bal_ref   = '0;
                        end
                    end
                    default: begin
                        n_running   = 1'b0;
                        n_balancing = 1'b0;
                        n_paired    = 1'b0;
                        n_bva       = 1'b0;
                        n_selb      = 1'b0;
                        n_cyc_ref   = '0;
                        n_bal_ref   = '0;
                    end
                endcase
            end
            pvcs_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_selb  = w_div_q;
                    n_state = pvcs_pkg::ST_DONE;
                end
            end
            pvcs_pkg::ST_DONE: begin
                if (r_balancing && r_bva) begin
                    if (r_selb) begin
                        w_vb = 1'b1;
                    end else begin
                        w_va = 1'b1;
                    end
                end
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid             = 1'b1;
                    n_out_data.pump_on      = r_running;
                    n_out_data.valve_a_open = w_va;
                    n_out_data.valve_b_open = w_vb;
                    n_out_data.is_running   = r_running;
                    n_out_data.is_balancing = r_balancing;
                    n_state                 = pvcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pvcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pvcs_pkg::ST_IDLE;
            r_running   <= 1'b0;
            r_balancing <= 1'b0;
            r_paired    <= 1'b0;
            r_bva       <= 1'b0;
            r_selb      <= 1'b0;
            r_cyc_ref   <= '0;
            r_bal_ref   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_running   <= n_running;
            r_balancing <= n_balancing;
            r_paired    <= n_paired;
            r_bva       <= n_bva;
            r_selb      <= n_selb;
            r_cyc_ref   <= n_cyc_ref;
            r_bal_ref   <= n_bal_ref;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (w_in_acc) begin
            r_kind <= i_in_data.kind;
            r_now  <= w_now64[TIME_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toggle_int <= pvcs_pkg::RST_TOGGLE_INTERVAL;
            r_bal_delay  <= pvcs_pkg::RST_BALANCE_DELAY;
            r_bal_window <= pvcs_pkg::RST_BALANCE_WINDOW;
            r_bal_alt    <= pvcs_pkg::RST_BALANCE_ALT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pvcs_pkg::CFG_TOGGLE_INTERVAL: r_toggle_int <= i_cfg_data;
                pvcs_pkg::CFG_BALANCE_DELAY:   r_bal_delay  <= i_cfg_data;
                pvcs_pkg::CFG_BALANCE_WINDOW:  r_bal_window <= i_cfg_data;
                pvcs_pkg::CFG_BALANCE_ALT:     r_bal_alt    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire
